FILE: hdl/blale_pkg.sv
package blale_pkg;

    // Request kinds as they arrive on the kind field.
    typedef enum logic [2:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_POP_BACK   = 3'd1,
        KIND_PUSH_FRONT = 3'd2,
        KIND_POP_FRONT  = 3'd3,
        KIND_INSERT     = 3'd4,
        KIND_ERASE      = 3'd5,
        KIND_FIND       = 3'd6
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_FIND  = 2'd3
    } cell_op_t;

    // Command to the chain: strobe marks the cycle an item is taken.
    typedef struct packed {
        logic     strobe;
        cell_op_t op;
    } cell_cmd_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESULT = 1'b1
    } state_t;

    localparam int FIELD_POS_W   = 7;
    localparam int FIELD_VALUE_W = 8;
    localparam int FIELD_INDEX_W = 6;
    localparam int FIELD_COUNT_W = 7;

endpackage

FILE: hdl/blale_cell.sv
module blale_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 8,
    parameter int IW         = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  blale_pkg::cell_cmd_t   cmd,
    input  logic [IW-1:0]          pos,
    input  logic [IW-1:0]          count,
    input  logic [DATA_WIDTH-1:0]  key,
    input  logic [DATA_WIDTH-1:0]  lower_data,
    input  logic [DATA_WIDTH-1:0]  upper_data,
    output logic [DATA_WIDTH-1:0]  data,
    output logic                   hit
);
    import blale_pkg::*;

    localparam logic [IW-1:0] IDX_C = IW'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit_reg;
    logic                  hit_next;

    // Pick this cell's new element from its neighbors or the key.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.strobe)
        begin
            case (cmd.op)
                OP_OPEN:
                begin
                    if (IDX_C > pos)
                        data_next = lower_data;
                    else if (IDX_C == pos)
                        data_next = key;
                end
                OP_CLOSE:
                begin
                    if (IDX_C >= pos)
                        data_next = upper_data;
                end
                default:
                begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    // A hit counts only for a find and only inside the occupied range.
    always_comb
    begin
        hit_next = hit_reg;
        if (cmd.strobe)
            hit_next = (cmd.op == OP_FIND) && (data_reg == key) && (IDX_C < count);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

FILE: hdl/bounded_array_list_engine_unit.sv
// Channel | Handshake            | Payload
// ------- | -------------------- | ------------------------------------------
// input   | in_valid / in_ready  | kind, position, value
// output  | out_valid / out_ready| status, found, found_index, count_after
//
// In the accept cycle every cell of the chain shifts or compares at once;
// in the result state the lowest hit is encoded and the output register is
// loaded once it is free. No new item is taken until that result is loaded.
// Reset clears the count and control state; element storage is not cleared.
// A stalled output holds the result cycle until the output register frees.
module bounded_array_list_engine_unit #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           kind,
    input  logic [blale_pkg::FIELD_POS_W-1:0]    position,
    input  logic [blale_pkg::FIELD_VALUE_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           status,
    output logic                                 found,
    output logic [blale_pkg::FIELD_INDEX_W-1:0]  found_index,
    output logic [blale_pkg::FIELD_COUNT_W-1:0]  count_after
);
    import blale_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int IW = (CW > FIELD_POS_W) ? CW : FIELD_POS_W;
    localparam logic [IW-1:0] CAP_C = IW'(CAPACITY);

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    status_t        pend_status_reg;
    status_t        pend_status_next;

    logic           out_valid_reg;
    status_t        out_status_reg;
    logic           out_found_reg;
    logic [AW-1:0]  out_index_reg;
    logic [CW-1:0]  out_count_reg;

    logic           accept;
    logic           load_out;
    cell_cmd_t      cmd;
    logic [IW-1:0]  cmd_pos;
    logic [IW-1:0]  cnt_x;
    logic [IW-1:0]  pos_x;
    logic           is_full;
    logic           is_empty;
    logic [DATA_WIDTH-1:0] key;
    logic [DATA_WIDTH+FIELD_VALUE_W-1:0] value_ext;

    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]   hits;
    logic [AW-1:0]         hit_index;

    logic [AW+FIELD_INDEX_W-1:0] index_ext;
    logic [CW+FIELD_COUNT_W-1:0] count_ext;

    // Lowest set bit of the hit vector.
    function automatic logic [AW-1:0] lowest_hit(input logic [CAPACITY-1:0] h);
        logic [AW-1:0] idx;
        idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (h[i])
                idx = AW'(i);
        end
        return idx;
    endfunction

    assign accept   = in_valid && in_ready;
    assign load_out = (state_reg == ST_RESULT) && (!out_valid_reg || out_ready);

    assign value_ext = {{DATA_WIDTH{1'b0}}, value};
    assign key       = value_ext[DATA_WIDTH-1:0];
    assign cnt_x     = IW'(count_reg);
    assign pos_x     = IW'(position);
    assign is_full   = (cnt_x == CAP_C);
    assign is_empty  = (count_reg == '0);

    // Decode the request against the current count.
    always_comb
    begin
        cmd.strobe       = accept;
        cmd.op           = OP_HOLD;
        cmd_pos          = '0;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        if (accept)
        begin
            pend_status_next = STAT_OK;
            case (kind_t'(kind))
                KIND_PUSH_BACK:
                begin
                    if (is_full)
                        pend_status_next = STAT_FULL;
                    else
                    begin
                        cmd.op     = OP_OPEN;
                        cmd_pos    = cnt_x;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_POP_BACK:
                begin
                    if (is_empty)
                        pend_status_next = STAT_EMPTY;
                    else
                        count_next = count_reg - 1'b1;
                end
                KIND_PUSH_FRONT:
                begin
                    if (is_full)
                        pend_status_next = STAT_FULL;
                    else
                    begin
                        cmd.op     = OP_OPEN;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (is_empty)
                        pend_status_next = STAT_EMPTY;
                    else
                    begin
                        cmd.op     = OP_CLOSE;
                        count_next = count_reg - 1'b1;
                    end
                end
                KIND_INSERT:
                begin
                    if (pos_x > cnt_x)
                        pend_status_next = STAT_RANGE;
                    else if (is_full)
                        pend_status_next = STAT_FULL;
                    else
                    begin
                        cmd.op     = OP_OPEN;
                        cmd_pos    = pos_x;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_ERASE:
                begin
                    if (is_empty)
                        pend_status_next = STAT_EMPTY;
                    else if (pos_x >= cnt_x)
                        pend_status_next = STAT_RANGE;
                    else
                    begin
                        cmd.op     = OP_CLOSE;
                        cmd_pos    = pos_x;
                        count_next = count_reg - 1'b1;
                    end
                end
                KIND_FIND:
                begin
                    cmd.op = OP_FIND;
                end
                default:
                begin
                    cmd.op = OP_HOLD;
                end
            endcase
        end
    end

    // Chain of element cells, each fed by both neighbors.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower_w;
        logic [DATA_WIDTH-1:0] upper_w;

        if (g == 0)
        begin : g_first
            assign lower_w = '0;
        end
        else
        begin : g_mid_lo
            assign lower_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper_w = '0;
        end
        else
        begin : g_mid_hi
            assign upper_w = cell_data[g+1];
        end

        blale_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .pos        (cmd_pos),
            .count      (cnt_x),
            .key        (key),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .data       (cell_data[g]),
            .hit        (hits[g])
        );
    end

    assign hit_index = lowest_hit(hits);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
                in_ready = 1'b1;
            default:
                in_ready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        if (load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_found_reg  <= |hits;
            out_index_reg  <= hit_index;
            out_count_reg  <= count_reg;
        end
    end

    assign index_ext   = {{FIELD_INDEX_W{1'b0}}, out_index_reg};
    assign count_ext   = {{FIELD_COUNT_W{1'b0}}, out_count_reg};

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign found_index = index_ext[FIELD_INDEX_W-1:0];
    assign count_after = count_ext[FIELD_COUNT_W-1:0];

endmodule

FILE: hdl/blale_checker.sv
module blale_checker #(
    parameter int CAPACITY = 64
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [1:0]                           status,
    input logic                                 found,
    input logic [blale_pkg::FIELD_INDEX_W-1:0]  found_index,
    input logic [blale_pkg::FIELD_COUNT_W-1:0]  count_after
);
    import blale_pkg::*;

    // A result held back by the consumer stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(count_after))
        else $error("output item changed while stalled");

    // One item at a time: input closes right after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken in back-to-back cycles");

    // A find that hits reports success.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == STAT_OK)
        else $error("found with non-ok status");

    // A miss reports index zero.
    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> found_index == '0)
        else $error("nonzero index without a hit");

    // The reported count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (CAPACITY < 128) |-> 32'(count_after) <= CAPACITY)
        else $error("count beyond capacity");

endmodule

bind bounded_array_list_engine_unit blale_checker #(.CAPACITY(CAPACITY)) u_blale_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .found_index (found_index),
    .count_after (count_after)
);

FILE: verif/bounded_array_list_engine_unit_test.sv
module bounded_array_list_engine_unit_test;
    import blale_pkg::*;

    localparam int LIST_DEPTH = 64;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int MAX_PRINTED = 40;
    localparam int DRAIN_CYCLES = 8;

    // One result item as the block should deliver it.
    typedef struct {
        status_t                  status;
        logic                     found;
        logic [FIELD_INDEX_W-1:0] index;
        logic [FIELD_COUNT_W-1:0] count;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [2:0]               kind;
    logic [FIELD_POS_W-1:0]   position;
    logic [FIELD_VALUE_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               status;
    logic                     found;
    logic [FIELD_INDEX_W-1:0] found_index;
    logic [FIELD_COUNT_W-1:0] count_after;

    // Shadow copy of the list contents and the results still owed by the block.
    logic [FIELD_VALUE_W-1:0] shadow_list[$];
    list_result_t             pending_results[$];

    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   mismatch_count;
    int   quiet_cycles;
    logic hold_req;
    logic hold_on;
    bit   grow_list;

    bounded_array_list_engine_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .count_after (count_after)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply one request to the shadow list and return the result it must give.
    function automatic list_result_t apply_request(input logic [2:0] k,
                                                   input logic [FIELD_POS_W-1:0] p,
                                                   input logic [FIELD_VALUE_W-1:0] v);
        list_result_t r;
        int           held;
        r.status = STAT_OK;
        r.found  = 1'b0;
        r.index  = '0;
        held     = shadow_list.size();
        case (k)
            KIND_PUSH_BACK:
                if (held >= LIST_DEPTH) r.status = STAT_FULL;
                else shadow_list.push_back(v);
            KIND_POP_BACK:
                if (held == 0) r.status = STAT_EMPTY;
                else void'(shadow_list.pop_back());
            KIND_PUSH_FRONT:
                if (held >= LIST_DEPTH) r.status = STAT_FULL;
                else shadow_list.push_front(v);
            KIND_POP_FRONT:
                if (held == 0) r.status = STAT_EMPTY;
                else void'(shadow_list.pop_front());
            KIND_INSERT:
                // The position is checked before the fill level.
                if (p > held) r.status = STAT_RANGE;
                else if (held >= LIST_DEPTH) r.status = STAT_FULL;
                else shadow_list.insert(p, v);
            KIND_ERASE:
                if (held == 0) r.status = STAT_EMPTY;
                else if (p >= held) r.status = STAT_RANGE;
                else shadow_list.delete(p);
            KIND_FIND:
                for (int i = 0; i < held; i++)
                begin
                    if (shadow_list[i] == v)
                    begin
                        r.found = 1'b1;
                        r.index = FIELD_INDEX_W'(i);
                        break;
                    end
                end
            default:
                ;
        endcase
        r.count = FIELD_COUNT_W'(shadow_list.size());
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Offer one item, wait for its acceptance and record what it must produce.
    task automatic send_item(input logic [2:0] k, input logic [FIELD_POS_W-1:0] p,
                             input logic [FIELD_VALUE_W-1:0] v);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        kind     <= k;
        position <= p;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(apply_request(k, p, v));
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct    <= sender_pct;
        receiver_stall_pct <= receiver_pct;
    endtask

    // Values come from a small set often, so that find meets duplicates.
    function automatic logic [FIELD_VALUE_W-1:0] pick_value();
        if ($urandom_range(99) < 30)
            return FIELD_VALUE_W'($urandom_range(7));
        return FIELD_VALUE_W'($urandom_range(255));
    endfunction

    // Check every result item against the oldest expectation; drive the receiver side.
    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result item with no request outstanding");
            else
            begin
                want = pending_results.pop_front();
                if (status != want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
                if (found != want.found)
                    report_mismatch($sformatf("found %0d, wanted %0d", found, want.found));
                if (found_index != want.index)
                    report_mismatch($sformatf("found_index %0d, wanted %0d",
                                              found_index, want.index));
                if (count_after != want.count)
                    report_mismatch($sformatf("count_after %0d, wanted %0d",
                                              count_after, want.count));
            end
        end
        if (hold_on)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Long receiver hold-off, counted here once requested.
    initial
    begin
        hold_on = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_on <= 1'b0;
            end
        end
    end

    // End the run when no item moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[bounded_array_list_engine_unit] ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Empty-list cases, range checks, kind 7, duplicates and lowest-index find.
    task automatic test_directed();
        set_idling(0, 0);
        send_item(KIND_POP_BACK, 0, 8'h00);
        send_item(KIND_POP_FRONT, 0, 8'h00);
        send_item(KIND_ERASE, 0, 8'h00);
        send_item(KIND_ERASE, 127, 8'hFF);
        send_item(KIND_FIND, 0, 8'h00);
        send_item(KIND_UNUSED, 127, 8'hFF);
        send_item(KIND_INSERT, 1, 8'h11);
        send_item(KIND_INSERT, 127, 8'h22);
        send_item(KIND_INSERT, 0, 8'hFF);
        send_item(KIND_PUSH_BACK, 127, 8'h00);
        send_item(KIND_PUSH_FRONT, 64, 8'hA5);
        send_item(KIND_INSERT, 3, 8'h5A);
        send_item(KIND_INSERT, 2, 8'hFF);
        send_item(KIND_FIND, 0, 8'hFF);
        send_item(KIND_FIND, 0, 8'h5A);
        send_item(KIND_FIND, 0, 8'h3C);
        send_item(KIND_ERASE, 5, 8'h00);
        send_item(KIND_ERASE, 127, 8'h00);
        send_item(KIND_ERASE, 1, 8'h00);
        send_item(KIND_POP_FRONT, 0, 8'h00);
        send_item(KIND_POP_BACK, 0, 8'h00);
        send_item(KIND_UNUSED, 0, 8'h00);
    endtask

    // Fill the list to capacity, try every kind of growth at the limit, then empty it.
    task automatic test_full_list();
        int sel;
        set_idling(54, 0);
        while (shadow_list.size() < LIST_DEPTH)
        begin
            sel = $urandom_range(2);
            if (sel == 0)
                send_item(KIND_PUSH_BACK, 7'($urandom_range(127)),
                          8'(128 + shadow_list.size()));
            else if (sel == 1)
                send_item(KIND_PUSH_FRONT, 7'($urandom_range(127)),
                          8'(128 + shadow_list.size()));
            else
                send_item(KIND_INSERT, 7'($urandom_range(shadow_list.size())),
                          8'(128 + shadow_list.size()));
        end
        send_item(KIND_PUSH_BACK, 0, 8'h01);
        send_item(KIND_PUSH_FRONT, 0, 8'h02);
        send_item(KIND_INSERT, 64, 8'h03);
        send_item(KIND_INSERT, 65, 8'h04);
        send_item(KIND_INSERT, 127, 8'h05);
        send_item(KIND_FIND, 0, shadow_list[LIST_DEPTH-1]);
        send_item(KIND_FIND, 0, shadow_list[0]);
        send_item(KIND_ERASE, 64, 8'h00);
        send_item(KIND_ERASE, 63, 8'h00);
        send_item(KIND_PUSH_BACK, 0, 8'h06);
        set_idling(0, 54);
        while (shadow_list.size() > 0)
        begin
            sel = $urandom_range(2);
            if (sel == 0)
                send_item(KIND_POP_BACK, 0, 8'h00);
            else if (sel == 1)
                send_item(KIND_POP_FRONT, 0, 8'h00);
            else
                send_item(KIND_ERASE, 7'($urandom_range(shadow_list.size() - 1)), 8'h00);
        end
        send_item(KIND_POP_BACK, 0, 8'h00);
    endtask

    // Random requests, drifting between an empty and a full list.
    task automatic test_random_mix(input int items, input int sender_pct,
                                   input int receiver_pct);
        int held;
        int r;
        set_idling(sender_pct, receiver_pct);
        for (int n = 0; n < items; n++)
        begin
            held = shadow_list.size();
            if (held >= LIST_DEPTH) grow_list = 1'b0;
            if (held == 0) grow_list = 1'b1;
            r = $urandom_range(99);
            if (r < 5)
                send_item(KIND_UNUSED, 7'($urandom_range(127)), 8'($urandom_range(255)));
            else if (r < 25)
            begin
                if (held > 0 && $urandom_range(99) < 70)
                    send_item(KIND_FIND, 7'($urandom_range(127)),
                              shadow_list[$urandom_range(held - 1)]);
                else
                    send_item(KIND_FIND, 7'($urandom_range(127)), pick_value());
            end
            else if ($urandom_range(99) < (grow_list ? 85 : 15))
            begin
                r = $urandom_range(2);
                if (r == 0)
                    send_item(KIND_PUSH_BACK, 7'($urandom_range(127)), pick_value());
                else if (r == 1)
                    send_item(KIND_PUSH_FRONT, 7'($urandom_range(127)), pick_value());
                else if ($urandom_range(99) < 85)
                    send_item(KIND_INSERT, 7'($urandom_range(held)), pick_value());
                else
                    send_item(KIND_INSERT, 7'($urandom_range(127)), pick_value());
            end
            else
            begin
                r = $urandom_range(2);
                if (r == 0)
                    send_item(KIND_POP_BACK, 7'($urandom_range(127)), pick_value());
                else if (r == 1)
                    send_item(KIND_POP_FRONT, 7'($urandom_range(127)), pick_value());
                else if (held > 0 && $urandom_range(99) < 85)
                    send_item(KIND_ERASE, 7'($urandom_range(held - 1)), pick_value());
                else
                    send_item(KIND_ERASE, 7'($urandom_range(127)), pick_value());
            end
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering items.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        test_random_mix(24, 0, 0);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        kind               = '0;
        position           = '0;
        value              = '0;
        out_ready          = 1'b0;
        hold_req           = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_count     = 0;
        quiet_cycles       = 0;
        grow_list          = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_list();
        test_random_mix(95, 0, 0);
        test_random_mix(95, 54, 0);
        test_output_backpressure();
        test_random_mix(95, 0, 54);
        test_random_mix(95, 13, 13);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[bounded_array_list_engine_unit] OK");
        else
            $display("[bounded_array_list_engine_unit] ERROR");
        $finish;
    end

endmodule

FILE: bounded_array_list_engine_unit.f
hdl/blale_pkg.sv
hdl/blale_cell.sv
hdl/bounded_array_list_engine_unit.sv
hdl/blale_checker.sv
verif/bounded_array_list_engine_unit_test.sv
